/* rtl/core/pdh_pkg.sv */
// Shared types and constants for the presence debounce and heartbeat unit.
`timescale 1ns / 1ps

package pdh_pkg;

    // Field widths
    localparam int DIST_IN_W  = 16;
    localparam int DIST_W     = 13;
    localparam int DWELL_W    = 24;
    localparam int SEQ_W      = 16;
    localparam int REASON_W   = 2;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 32;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Readings at or above this distance are rejected
    localparam logic [DIST_IN_W-1:0] VALID_LIMIT_MM = 16'd8000;

    // Input kind carried on tuser
    localparam logic REQ_TICK    = 1'b0;
    localparam logic REQ_READING = 1'b1;

    // Report reasons carried on tuser
    typedef enum logic [REASON_W-1:0] {
        REASON_BOOT      = 2'd0,
        REASON_CHANGE    = 2'd1,
        REASON_HEARTBEAT = 2'd2
    } t_reason;

    // Register index (byte address / 4)
    typedef enum logic [2:0] {
        REG_MIN_DIST   = 3'd0,
        REG_MAX_DIST   = 3'd1,
        REG_OCC_DWELL  = 3'd2,
        REG_VAC_DWELL  = 3'd3,
        REG_HB_PERIOD  = 3'd4
    } t_reg_idx;

    // Register reset values
    localparam logic [DIST_W-1:0]  RST_MIN_DIST  = 13'd30;
    localparam logic [DIST_W-1:0]  RST_MAX_DIST  = 13'd1200;
    localparam logic [DWELL_W-1:0] RST_OCC_DWELL = 24'd5000;
    localparam logic [DWELL_W-1:0] RST_VAC_DWELL = 24'd30000;
    localparam logic [DWELL_W-1:0] RST_HB_PERIOD = 24'd60000;

endpackage

/* rtl/core/presence_debounce_heartbeat_unit.sv */
// Presence debounce with heartbeat: top level with config registers and datapath.
`timescale 1ns / 1ps

// Usage
//   Input stream (s_axis_*): one transfer per event. tuser = 0 is a 1 ms tick,
//   tuser = 1 is a distance reading in tdata (distance, timeout flag).
//   Output stream (m_axis_*): zero or one report per input transfer, carrying
//   sequence number, occupancy and last valid distance; tuser holds the reason
//   (boot, occupancy change, heartbeat).
//   APB port: five registers at byte addresses 0x00..0x10 (window limits,
//   dwell times, heartbeat period). pready is tied high; write only when idle.
// Timing
//   An input transfer is captured in an input register, evaluated by one pass
//   of compare/increment logic once the output register is free, and the
//   report lands in the output register, which drives m_axis_tvalid.
//   Throughput is one item per cycle while the output is not stalled.
// Reset
//   Synchronous, active low. Registers return to their defaults, streaks and
//   timers clear, and the first item afterwards produces the boot report.
// Backpressure
//   A stalled output register holds its report; the input register keeps one
//   more item, after which s_axis_tready drops until the receiver takes data.
module presence_debounce_heartbeat_unit #(
    parameter int TIMER_BITS = 24
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: [15:0] distance_mm, [16] sensor_timeout, [23:17] zero
    input  logic [pdh_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // tuser: [0] req_type
    input  logic [0:0]                       s_axis_tuser,
    // Output stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: [15:0] report_seq, [16] occupied_now, [29:17] last_valid_mm, [31:30] zero
    output logic [pdh_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // tuser: [1:0] report_reason
    output logic [pdh_pkg::REASON_W-1:0]     m_axis_tuser,
    // Configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pdh_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [pdh_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [pdh_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    localparam int CMP_W = (TIMER_BITS > pdh_pkg::DWELL_W) ? TIMER_BITS : pdh_pkg::DWELL_W;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    // ---------------- configuration registers ----------------
    logic [pdh_pkg::DIST_W-1:0]  r_min_dist;
    logic [pdh_pkg::DIST_W-1:0]  r_max_dist;
    logic [pdh_pkg::DWELL_W-1:0] r_occ_dwell;
    logic [pdh_pkg::DWELL_W-1:0] r_vac_dwell;
    logic [pdh_pkg::DWELL_W-1:0] r_hb_period;
    logic                        w_cfg_wr;
    logic [2:0]                  w_cfg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel & penable & pwrite & pready;
    assign w_cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_dist  <= pdh_pkg::RST_MIN_DIST;
            r_max_dist  <= pdh_pkg::RST_MAX_DIST;
            r_occ_dwell <= pdh_pkg::RST_OCC_DWELL;
            r_vac_dwell <= pdh_pkg::RST_VAC_DWELL;
            r_hb_period <= pdh_pkg::RST_HB_PERIOD;
        end else if (w_cfg_wr) begin
            unique case (w_cfg_idx)
                pdh_pkg::REG_MIN_DIST:  r_min_dist  <= pwdata[pdh_pkg::DIST_W-1:0];
                pdh_pkg::REG_MAX_DIST:  r_max_dist  <= pwdata[pdh_pkg::DIST_W-1:0];
                pdh_pkg::REG_OCC_DWELL: r_occ_dwell <= pwdata[pdh_pkg::DWELL_W-1:0];
                pdh_pkg::REG_VAC_DWELL: r_vac_dwell <= pwdata[pdh_pkg::DWELL_W-1:0];
                pdh_pkg::REG_HB_PERIOD: r_hb_period <= pwdata[pdh_pkg::DWELL_W-1:0];
                default: ;  // unmapped, ignored
            endcase
        end
    end

    always_comb begin
        unique case (w_cfg_idx)
            pdh_pkg::REG_MIN_DIST:  prdata = pdh_pkg::APB_DATA_W'(r_min_dist);
            pdh_pkg::REG_MAX_DIST:  prdata = pdh_pkg::APB_DATA_W'(r_max_dist);
            pdh_pkg::REG_OCC_DWELL: prdata = pdh_pkg::APB_DATA_W'(r_occ_dwell);
            pdh_pkg::REG_VAC_DWELL: prdata = pdh_pkg::APB_DATA_W'(r_vac_dwell);
            pdh_pkg::REG_HB_PERIOD: prdata = pdh_pkg::APB_DATA_W'(r_hb_period);
            default:                prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    logic r_in_valid;
    logic r_out_valid;
    logic w_out_free;   // output register can take a new report this cycle
    logic w_step;       // input register item is evaluated this cycle

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_step        = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_out_free;

    // ---------------- input register ----------------
    logic                           r_in_type;
    logic [pdh_pkg::DIST_IN_W-1:0]  r_in_dist;
    logic                           r_in_tmo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_type <= s_axis_tuser[0];
            r_in_dist <= s_axis_tdata[pdh_pkg::DIST_IN_W-1:0];
            r_in_tmo  <= s_axis_tdata[pdh_pkg::DIST_IN_W];
        end
    end

    // ---------------- tracker state ----------------
    logic                        r_occ;
    logic                        r_pstreak;
    logic                        r_astreak;
    logic [TIMER_BITS-1:0]       r_pelapsed;
    logic [TIMER_BITS-1:0]       r_aelapsed;
    logic [TIMER_BITS-1:0]       r_since;
    logic [pdh_pkg::SEQ_W-1:0]   r_seq;
    logic [pdh_pkg::DIST_W-1:0]  r_last_dist;
    logic                        r_boot;

    logic                        n_occ;
    logic                        n_pstreak;
    logic                        n_astreak;
    logic [TIMER_BITS-1:0]       n_pelapsed;
    logic [TIMER_BITS-1:0]       n_aelapsed;
    logic [TIMER_BITS-1:0]       n_since;
    logic [pdh_pkg::SEQ_W-1:0]   n_seq;
    logic [pdh_pkg::DIST_W-1:0]  n_last_dist;
    logic                        n_emit;
    pdh_pkg::t_reason            n_reason;

    logic w_rd_valid;
    logic w_present;
    logic w_changed;
    logic [TIMER_BITS-1:0] w_since_upd;

    assign w_rd_valid = !r_in_tmo && (r_in_dist < pdh_pkg::VALID_LIMIT_MM);
    assign w_present  = w_rd_valid
                     && (r_in_dist >= pdh_pkg::DIST_IN_W'(r_min_dist))
                     && (r_in_dist <= pdh_pkg::DIST_IN_W'(r_max_dist));

    always_comb begin
        n_occ       = r_occ;
        n_pstreak   = r_pstreak;
        n_astreak   = r_astreak;
        n_pelapsed  = r_pelapsed;
        n_aelapsed  = r_aelapsed;
        n_last_dist = r_last_dist;
        w_since_upd = r_since;
        w_changed   = 1'b0;

        if (r_in_type == pdh_pkg::REQ_TICK) begin
            // saturating timers
            if (r_pstreak && r_pelapsed != TIMER_MAX) n_pelapsed = r_pelapsed + 1'b1;
            if (r_astreak && r_aelapsed != TIMER_MAX) n_aelapsed = r_aelapsed + 1'b1;
            if (r_since != TIMER_MAX)                 w_since_upd = r_since + 1'b1;
        end else begin
            if (w_rd_valid) n_last_dist = r_in_dist[pdh_pkg::DIST_W-1:0];
            if (w_present) begin
                n_astreak  = 1'b0;
                n_aelapsed = '0;
                n_pstreak  = 1'b1;
                n_pelapsed = r_pstreak ? r_pelapsed : '0;
                if (!r_occ && CMP_W'(n_pelapsed) >= CMP_W'(r_occ_dwell)) begin
                    n_occ     = 1'b1;
                    w_changed = 1'b1;
                end
            end else begin
                n_pstreak  = 1'b0;
                n_pelapsed = '0;
                n_astreak  = 1'b1;
                n_aelapsed = r_astreak ? r_aelapsed : '0;
                if (r_occ && CMP_W'(n_aelapsed) >= CMP_W'(r_vac_dwell)) begin
                    n_occ     = 1'b0;
                    w_changed = 1'b1;
                end
            end
        end

        // report selection: boot, then change, then heartbeat
        n_emit   = 1'b1;
        n_reason = pdh_pkg::REASON_HEARTBEAT;
        if (r_boot) begin
            n_reason = pdh_pkg::REASON_BOOT;
        end else if (w_changed) begin
            n_reason = pdh_pkg::REASON_CHANGE;
        end else if (CMP_W'(w_since_upd) < CMP_W'(r_hb_period)) begin
            n_emit = 1'b0;
        end

        n_since = n_emit ? '0 : w_since_upd;
        n_seq   = n_emit ? r_seq + 1'b1 : r_seq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= 1'b0;
            r_pstreak   <= 1'b0;
            r_astreak   <= 1'b0;
            r_pelapsed  <= '0;
            r_aelapsed  <= '0;
            r_since     <= '0;
            r_seq       <= '0;
            r_last_dist <= '0;
            r_boot      <= 1'b1;
        end else if (w_step) begin
            r_occ       <= n_occ;
            r_pstreak   <= n_pstreak;
            r_astreak   <= n_astreak;
            r_pelapsed  <= n_pelapsed;
            r_aelapsed  <= n_aelapsed;
            r_since     <= n_since;
            r_seq       <= n_seq;
            r_last_dist <= n_last_dist;
            r_boot      <= 1'b0;
        end
    end

    // ---------------- output register ----------------
    logic [pdh_pkg::SEQ_W-1:0]  r_out_seq;
    logic                       r_out_occ;
    logic [pdh_pkg::DIST_W-1:0] r_out_dist;
    pdh_pkg::t_reason           r_out_reason;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= n_emit;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && n_emit) begin
            r_out_seq    <= r_seq;
            r_out_occ    <= n_occ;
            r_out_dist   <= n_last_dist;
            r_out_reason <= n_reason;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_dist, r_out_occ, r_out_seq};
    assign m_axis_tuser  = r_out_reason;

endmodule

/* rtl/core/pdh_checker.sv */
// Port-level checker for the presence debounce unit, bound to the top level.
`timescale 1ns / 1ps

module pdh_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [pdh_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic [pdh_pkg::REASON_W-1:0]  m_axis_tuser
);

    logic                      r_seen;
    logic [pdh_pkg::SEQ_W-1:0] r_last_seq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            r_seen <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            r_last_seq <= m_axis_tdata[pdh_pkg::SEQ_W-1:0];
        end
    end

    // stalled report holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("report changed while stalled");

    // first report after reset is the boot report, and only that one
    a_boot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_seen == (m_axis_tuser != pdh_pkg::REASON_BOOT)))
        else $error("boot report out of place");

    // sequence numbers advance by one per report
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_seen |->
            m_axis_tdata[pdh_pkg::SEQ_W-1:0] == r_last_seq + 1'b1)
        else $error("report sequence gap");

    // last valid distance never reaches the rejection limit
    a_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            pdh_pkg::DIST_IN_W'(m_axis_tdata[29:17]) < pdh_pkg::VALID_LIMIT_MM)
        else $error("last distance out of range");

    // with the output register empty the input side is open
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

endmodule

bind presence_debounce_heartbeat_unit pdh_checker u_pdh_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

/* tb/presence_debounce_heartbeat_unit_tb.sv */
// Self-checking testbench for the presence debounce and heartbeat unit.
`timescale 1ns / 1ps

// Drives ticks and distance readings into the input stream, runs its own
// model of the debounce/heartbeat logic on every accepted transfer and
// compares each report leaving the output stream with the oldest prediction.
// Registers are reprogrammed over APB between phases, only with the block
// idle; each register write is read back. Both stream sides idle at random.
module presence_debounce_heartbeat_unit_tb;
    import pdh_pkg::*;

    localparam int TIMER_W        = 24;
    localparam int SETTLE_CYCLES  = 8;       // pipeline is 2 deep, leave margin
    localparam int DRAIN_LIMIT    = 2000;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int RANDOM_ITEMS   = 1300;
    localparam int PHASE_ITEMS    = 100;
    localparam int MAX_PRINTED    = 30;
    localparam int UNUSED_REG_LO  = 5;       // first index past the register file
    localparam int UNUSED_REG_HI  = 7;
    localparam int MAX_VALID_MM   = int'(VALID_LIMIT_MM) - 1;
    localparam logic [DWELL_W-1:0] DWELL_MAX = '1;

    typedef struct {
        logic        kind;
        logic [15:0] range_mm;
        logic        tmo;
    } t_sensor_event;

    typedef struct {
        logic [SEQ_W-1:0]  seq;
        logic              occ;
        logic [DIST_W-1:0] mm;
        t_reason           why;
    } t_occupancy_report;

    // ---------------------------------------------------------------
    // Clock, reset, DUT
    // ---------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #1 i_clk = ~i_clk;

    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [0:0]            s_axis_tuser  = REQ_TICK;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic [REASON_W-1:0]   m_axis_tuser;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    presence_debounce_heartbeat_unit #(
        .TIMER_BITS(TIMER_W)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // ---------------------------------------------------------------
    // Model state: register copies and debounce state
    // ---------------------------------------------------------------
    logic [DIST_W-1:0]  cfg_min    = RST_MIN_DIST;
    logic [DIST_W-1:0]  cfg_max    = RST_MAX_DIST;
    logic [DWELL_W-1:0] cfg_occ    = RST_OCC_DWELL;
    logic [DWELL_W-1:0] cfg_vac    = RST_VAC_DWELL;
    logic [DWELL_W-1:0] cfg_period = RST_HB_PERIOD;

    logic               occupied = 1'b0;
    logic               near_run = 1'b0;     // presence streak active
    logic               far_run  = 1'b0;     // absence streak active
    logic [TIMER_W-1:0] near_ms  = '0;
    logic [TIMER_W-1:0] far_ms   = '0;
    logic [TIMER_W-1:0] quiet_ms = '0;       // ticks since last report
    logic [SEQ_W-1:0]   next_seq = '0;
    logic [DIST_W-1:0]  last_mm  = '0;
    logic               boot_due = 1'b1;

    t_sensor_event     event_q[$];           // items waiting for the driver
    t_occupancy_report pending_reports[$];   // predicted, not yet seen

    int items_offered  = 0;
    int items_taken    = 0;
    int reports_seen   = 0;
    int queued_items   = 0;
    int mismatches     = 0;
    int change_reports = 0;
    int beat_reports   = 0;
    int settings_used  = 0;
    int cycle_count    = 0;

    // ---------------------------------------------------------------
    // Mismatch reporting
    // ---------------------------------------------------------------
    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    // ---------------------------------------------------------------
    // Debounce predictor
    // ---------------------------------------------------------------
    function automatic logic [TIMER_W-1:0] bump(input logic [TIMER_W-1:0] t);
        return (&t) ? t : t + 1'b1;          // saturating
    endfunction

    function automatic void step_debounce(input logic kind, input logic [15:0] range_mm,
                                          input logic tmo);
        logic              valid;
        logic              near;
        logic              flipped;
        t_occupancy_report rep;
        flipped = 1'b0;
        if (kind == REQ_TICK) begin
            if (near_run) near_ms = bump(near_ms);
            if (far_run) far_ms = bump(far_ms);
            quiet_ms = bump(quiet_ms);
        end else begin
            valid = !tmo && (range_mm < VALID_LIMIT_MM);
            if (valid) last_mm = range_mm[DIST_W-1:0];
            near = valid && (range_mm >= cfg_min) && (range_mm <= cfg_max);
            if (near) begin
                far_run = 1'b0;
                far_ms  = '0;
                if (!near_run) begin
                    near_run = 1'b1;
                    near_ms  = '0;
                end
                if (!occupied && near_ms >= cfg_occ) begin
                    occupied = 1'b1;
                    flipped  = 1'b1;
                end
            end else begin
                near_run = 1'b0;
                near_ms  = '0;
                if (!far_run) begin
                    far_run = 1'b1;
                    far_ms  = '0;
                end
                if (occupied && far_ms >= cfg_vac) begin
                    occupied = 1'b0;
                    flipped  = 1'b1;
                end
            end
        end
        // boot swallows a change or heartbeat on the same item
        if (boot_due) begin
            boot_due = 1'b0;
            rep.why  = REASON_BOOT;
        end else if (flipped) begin
            rep.why = REASON_CHANGE;
            change_reports++;
        end else if (quiet_ms >= cfg_period) begin
            rep.why = REASON_HEARTBEAT;
            beat_reports++;
        end else begin
            return;
        end
        rep.seq  = next_seq;
        rep.occ  = occupied;
        rep.mm   = last_mm;
        pending_reports.push_back(rep);
        next_seq = next_seq + 1'b1;
        quiet_ms = '0;
    endfunction

    function automatic logic [APB_DATA_W-1:0] reg_value(input int idx);
        case (idx)
            REG_MIN_DIST:  return APB_DATA_W'(cfg_min);
            REG_MAX_DIST:  return APB_DATA_W'(cfg_max);
            REG_OCC_DWELL: return APB_DATA_W'(cfg_occ);
            REG_VAC_DWELL: return APB_DATA_W'(cfg_vac);
            REG_HB_PERIOD: return APB_DATA_W'(cfg_period);
            default:       return '0;
        endcase
    endfunction

    function automatic void apply_reg(input int idx, input logic [APB_DATA_W-1:0] data);
        case (idx)
            REG_MIN_DIST:  cfg_min    = data[DIST_W-1:0];
            REG_MAX_DIST:  cfg_max    = data[DIST_W-1:0];
            REG_OCC_DWELL: cfg_occ    = data[DWELL_W-1:0];
            REG_VAC_DWELL: cfg_vac    = data[DWELL_W-1:0];
            REG_HB_PERIOD: cfg_period = data[DWELL_W-1:0];
            default: ;                        // no register there
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Monitor: both streams sampled at the rising edge
    // ---------------------------------------------------------------
    task automatic check_report(input logic [M_TDATA_W-1:0] data,
                                input logic [REASON_W-1:0] why);
        t_occupancy_report want;
        if (pending_reports.size() == 0) begin
            note_mismatch($sformatf("report seq %0d with nothing pending", data[15:0]));
            return;
        end
        want = pending_reports.pop_front();
        if (data[15:0] !== want.seq)
            note_mismatch($sformatf("report_seq %0d, want %0d", data[15:0], want.seq));
        if (data[16] !== want.occ)
            note_mismatch($sformatf("seq %0d occupied_now %b, want %b",
                                    want.seq, data[16], want.occ));
        if (data[29:17] !== want.mm)
            note_mismatch($sformatf("seq %0d last_valid_mm %0d, want %0d",
                                    want.seq, data[29:17], want.mm));
        if (data[31:30] !== 2'b00)
            note_mismatch($sformatf("seq %0d tdata pad bits %b", want.seq, data[31:30]));
        if (why !== want.why)
            note_mismatch($sformatf("seq %0d report_reason %0d, want %0d",
                                    want.seq, why, want.why));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // check before predicting: a report can never stem from this edge's item
            if (m_axis_tvalid && m_axis_tready) begin
                reports_seen++;
                check_report(m_axis_tdata, m_axis_tuser);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                items_taken++;
                step_debounce(s_axis_tuser[0], s_axis_tdata[15:0], s_axis_tdata[16]);
            end
        end
    end

    // ---------------------------------------------------------------
    // Input driver: pops event_q, random gap after each transfer
    // ---------------------------------------------------------------
    int            tx_gap    = 0;
    bit            tx_steady = 1'b0;
    t_sensor_event tx_ev;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && items_taken != items_offered) begin
            // transfer still waiting for tready
        end else if (tx_gap != 0) begin
            tx_gap--;
            s_axis_tvalid <= 1'b0;
        end else if (event_q.size() != 0) begin
            tx_ev = event_q.pop_front();
            s_axis_tdata  <= {7'd0, tx_ev.tmo, tx_ev.range_mm};
            s_axis_tuser  <= tx_ev.kind;
            s_axis_tvalid <= 1'b1;
            items_offered++;
            if ($urandom_range(0, 39) == 0) tx_steady = !tx_steady;
            tx_gap = tx_steady ? 0 : $urandom_range(0, 4);
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Output receiver: random stall before each report
    // ---------------------------------------------------------------
    int rx_hold       = 0;
    int reports_paced = 0;
    bit rx_steady     = 1'b0;

    always @(negedge i_clk) begin
        if (reports_seen != reports_paced) begin
            reports_paced = reports_seen;
            if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
            rx_hold = rx_steady ? 0 : $urandom_range(0, 4);
        end
        if (rx_hold != 0) begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Watchdog
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d reports outstanding",
                     cycle_count, pending_reports.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // APB access, entered at a falling edge; apb_access returns at a rising edge
    // ---------------------------------------------------------------
    task automatic apb_access(input int idx, input bit wr, input logic [APB_DATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= APB_ADDR_W'(idx * 4);
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (wr)
            apply_reg(idx, data);
        else if (prdata !== reg_value(idx))
            note_mismatch($sformatf("register %0d reads 0x%0h, want 0x%0h",
                                    idx, prdata, reg_value(idx)));
    endtask

    task automatic apb_release();
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // random junk above the field width checks the write masking
    function automatic logic [APB_DATA_W-1:0] with_junk(input logic [APB_DATA_W-1:0] v,
                                                        input int width);
        logic [APB_DATA_W-1:0] mask;
        mask = (APB_DATA_W'(1) << width) - 1;
        return ($urandom() & ~mask) | (v & mask);
    endfunction

    task automatic program_settings(input int lo_mm, input int hi_mm, input int occ_ms,
                                    input int vac_ms, input int beat_ms, input bit ghost);
        apb_access(REG_MIN_DIST, 1'b1, with_junk(lo_mm, DIST_W));
        apb_access(REG_MIN_DIST, 1'b0, '0);
        apb_access(REG_MAX_DIST, 1'b1, with_junk(hi_mm, DIST_W));
        apb_access(REG_MAX_DIST, 1'b0, '0);
        apb_access(REG_OCC_DWELL, 1'b1, with_junk(occ_ms, DWELL_W));
        apb_access(REG_OCC_DWELL, 1'b0, '0);
        apb_access(REG_VAC_DWELL, 1'b1, with_junk(vac_ms, DWELL_W));
        apb_access(REG_VAC_DWELL, 1'b0, '0);
        apb_access(REG_HB_PERIOD, 1'b1, with_junk(beat_ms, DWELL_W));
        apb_access(REG_HB_PERIOD, 1'b0, '0);
        // write past the register file: must change nothing
        if (ghost)
            apb_access($urandom_range(UNUSED_REG_HI, UNUSED_REG_LO), 1'b1, $urandom());
        apb_release();
        settings_used++;
    endtask

    // ---------------------------------------------------------------
    // Stimulus builders
    // ---------------------------------------------------------------
    task automatic push_event(input logic kind, input logic [15:0] range_mm, input logic tmo);
        t_sensor_event ev;
        ev.kind     = kind;
        ev.range_mm = range_mm;
        ev.tmo      = tmo;
        event_q.push_back(ev);
        queued_items++;
    endtask

    // tick payload is don't-care, so fill it with noise
    task automatic push_tick();
        push_event(REQ_TICK, 16'($urandom_range(65535, 0)), 1'($urandom_range(1, 0)));
    endtask

    task automatic push_reading(input int range_mm, input bit tmo);
        push_event(REQ_READING, range_mm[15:0], tmo);
    endtask

    function automatic int window_top();
        return (int'(cfg_max) < MAX_VALID_MM) ? int'(cfg_max) : MAX_VALID_MM;
    endfunction

    // a reading that ends a presence streak: below/above window, invalid, timed out
    task automatic push_far_reading();
        int pick;
        pick = $urandom_range(0, 3);
        if (pick == 0 && cfg_min > 0)
            push_reading($urandom_range(int'(cfg_min) - 1, 0), 1'b0);
        else if (pick == 1 && int'(cfg_max) < MAX_VALID_MM)
            push_reading($urandom_range(MAX_VALID_MM, int'(cfg_max) + 1), 1'b0);
        else if (pick == 2)
            push_reading($urandom_range(65535, int'(VALID_LIMIT_MM)), 1'b0);
        else
            push_reading($urandom_range(65535, 0), 1'b1);
    endtask

    task automatic push_near_reading();
        if (int'(cfg_min) <= window_top())
            push_reading($urandom_range(window_top(), int'(cfg_min)), 1'b0);
        else
            push_far_reading();
    endtask

    // Mostly presence and absence runs with ticks between readings, so the
    // dwell timers actually expire; the rest is tick runs and raw noise.
    task automatic queue_random_traffic(input int quota);
        int start;
        int burst;
        start = queued_items;
        while (queued_items - start < quota) begin
            burst = $urandom_range(0, 9);
            if (burst <= 3) begin
                repeat ($urandom_range(4, 1)) begin
                    push_near_reading();
                    repeat ($urandom_range(6, 0)) push_tick();
                end
            end else if (burst <= 6) begin
                repeat ($urandom_range(4, 1)) begin
                    push_far_reading();
                    repeat ($urandom_range(6, 0)) push_tick();
                end
            end else if (burst == 7) begin
                repeat ($urandom_range(20, 1)) push_tick();
            end else begin
                repeat ($urandom_range(6, 1))
                    push_event(1'($urandom_range(1, 0)), 16'($urandom_range(65535, 0)),
                               1'($urandom_range(1, 0)));
            end
        end
    endtask

    // block idle: nothing queued, in flight or expected, then pipeline flush
    task automatic wait_settled();
        while (event_q.size() != 0 || items_taken != items_offered ||
               pending_reports.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic int dwell_pick();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return int'(DWELL_MAX);
        if (roll == 1) return $urandom_range(int'(DWELL_MAX), 0);
        return $urandom_range(8, 0);
    endfunction

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial begin
        int phase;
        int lo_mm;
        int hi_mm;
        int beat_ms;
        int roll;
        int waited;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults (window 30..1200): first item brings the boot report,
        // then window edges, the 8000 mm validity limit and timeouts.
        push_tick();
        push_reading(0, 1'b0);
        push_reading(29, 1'b0);
        push_reading(30, 1'b0);
        push_reading(1200, 1'b0);
        push_reading(1201, 1'b0);
        push_reading(MAX_VALID_MM, 1'b0);
        push_reading(int'(VALID_LIMIT_MM), 1'b0);
        push_reading(65535, 1'b0);
        push_reading(500, 1'b1);
        push_tick();
        wait_settled();

        // Short dwells: occupy after two ticks of presence, vacate after one
        // tick of absence, heartbeat every three ticks.
        program_settings(100, 200, 2, 1, 3, 1'b1);
        push_reading(150, 1'b0);
        push_tick();
        push_tick();
        push_reading(150, 1'b0);
        push_reading(300, 1'b0);
        push_tick();
        push_reading(int'(VALID_LIMIT_MM), 1'b0);
        repeat (4) push_tick();
        push_reading(150, 1'b1);
        wait_settled();

        // First phases pin the register extremes, including a zero period
        // (heartbeat on every quiet item); the rest draw settings at random.
        phase = 0;
        while (queued_items < RANDOM_ITEMS + 25) begin
            if (phase == 0) begin
                program_settings(0, (1 << DIST_W) - 1, 0, 0, 1, 1'b0);
            end else if (phase == 1) begin
                program_settings((1 << DIST_W) - 1, 0, int'(DWELL_MAX), int'(DWELL_MAX),
                                 int'(DWELL_MAX), 1'b1);
            end else if (phase == 2) begin
                program_settings(500, 500, 3, 2, 0, 1'b0);
            end else begin
                roll = $urandom_range(0, 5);
                if (roll == 0) begin
                    lo_mm = 0;
                    hi_mm = (1 << DIST_W) - 1;
                end else if (roll == 1) begin
                    lo_mm = $urandom_range((1 << DIST_W) - 1, 0);
                    hi_mm = $urandom_range((1 << DIST_W) - 1, 0);
                end else begin
                    lo_mm = $urandom_range(3000, 0);
                    hi_mm = lo_mm + $urandom_range(3000, 0);
                end
                roll = $urandom_range(0, 9);
                if (roll == 0)      beat_ms = 0;
                else if (roll == 1) beat_ms = $urandom_range(int'(DWELL_MAX), 0);
                else                beat_ms = $urandom_range(40, 1);
                program_settings(lo_mm, hi_mm, dwell_pick(), dwell_pick(), beat_ms,
                                 (phase % 3) == 0);
            end
            queue_random_traffic(PHASE_ITEMS);
            wait_settled();
            phase++;
        end

        // bounded drain so a lost report shows up as a leftover
        waited = 0;
        while (pending_reports.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        while (pending_reports.size() != 0) begin
            note_mismatch($sformatf("expected report seq %0d never arrived",
                                    pending_reports[0].seq));
            void'(pending_reports.pop_front());
        end

        $display("Covered %0d input transfers and %0d reports under %0d register settings",
                 items_taken, reports_seen, settings_used);
        $display("  %0d occupancy changes, %0d heartbeats, %0d mismatches",
                 change_reports, beat_reports, mismatches);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
